// ===== rtl/sha256_pkg.sv =====
// SHA-256 package: initial hash words, round constants and round functions.
// No dependencies.
`timescale 1ns / 1ps
package sha256_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned NumRounds = 64;

  localparam logic [WordW-1:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [WordW-1:0] RoundConst [NumRounds] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [WordW-1:0] rotr(input logic [WordW-1:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (WordW - n));
  endfunction

  function automatic logic [WordW-1:0] sig0(input logic [WordW-1:0] x);
    sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [WordW-1:0] sig1(input logic [WordW-1:0] x);
    sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [WordW-1:0] bsig0(input logic [WordW-1:0] x);
    bsig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [WordW-1:0] bsig1(input logic [WordW-1:0] x);
    bsig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } in_item_t;

  typedef struct packed {
    logic [WordW-1:0] digest_word;
    logic [2:0]       word_index;
    logic             last_word;
  } out_item_t;

endpackage

// ===== rtl/sha256_if.sv =====
// Valid/ready channel interfaces for message items and digest words.
// Depends on sha256_pkg.
`timescale 1ns / 1ps
interface sha256_in_if;
  import sha256_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface sha256_out_if;
  import sha256_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ===== rtl/sha256_message_digest_core.sv =====
// SHA-256 core top level: byte packing, padding, compression and digest output.
// Depends on sha256_pkg and sha256_if.
`timescale 1ns / 1ps
// At most one message byte per item, most significant first. A byte that does not
// finish a block is accepted in StIdle and packed in StPack. A byte that finishes a
// block also starts the compression: StRd0 loads the working variables and fetches
// the first word, StRound runs the 64 rounds, and StFin adds into the hash words.
// The block words sit in the schedule memory (16 x 32, one write and one read port,
// registered read); during the first 16 rounds the read for round r+1 overlaps
// round r, and a 16-word register window supplies the later schedule words. An
// item marked last adds pad bytes in StPad and the two length words in StLen, one
// or two compressions, and then 8 digest words out, one per accepted handshake.
// No item is taken while a block compresses or digest words are pending.
module sha256_message_digest_core (
  input logic clk_i,
  input logic rst_ni,
  sha256_in_if.sink    in_if,
  sha256_out_if.source out_if
);
  import sha256_pkg::*;

  typedef enum logic [3:0] {
    StIdle, StPack, StPad, StLen, StRd0, StRound, StFin, StOut
  } state_e;

  state_e            state_q;
  logic [WordW-1:0]  mem [16];
  logic [WordW-1:0]  rdata_q;
  logic [WordW-1:0]  wbuf_q;     // partial word being packed
  logic [5:0]        cnt_q;      // bytes in current block
  logic [63:0]       bitlen_q;
  logic [WordW-1:0]  h_q [8];
  logic [WordW-1:0]  v_q [8];
  logic [6:0]        rnd_q;
  logic              last_q;     // block is the final one of the message
  logic              padding_q;  // message ended, padding in progress
  logic              marked_q;   // 0x80 end marker already packed
  logic [2:0]        oidx_q;
  logic              lenph_q;
  // schedule word for the current round
  logic [WordW-1:0]  w_cur;
  logic [3:0]        rd_addr;

  // Rolling schedule window: from round 16 on it holds w[t-16] .. w[t-1]
  logic [WordW-1:0]  win_q [16];

  assign in_if.ready = (state_q == StIdle);
  assign out_if.valid = (state_q == StOut);
  assign out_if.payload.digest_word = h_q[oidx_q];
  assign out_if.payload.word_index  = oidx_q;
  assign out_if.payload.last_word   = (oidx_q == 3'd7);

  always_comb begin
    if (rnd_q < 7'd16) begin
      w_cur = rdata_q;
    end else begin
      w_cur = win_q[0] + sig0(win_q[1]) + win_q[9] + sig1(win_q[14]);
    end
  end
  assign rd_addr = rnd_q[3:0] + 4'd1;

  // Block store: written once per full word while packing or padding, and for each length word.
  logic             we;
  logic [3:0]       waddr;
  logic [WordW-1:0] wdata;
  always_comb begin
    we = 1'b0;
    waddr = cnt_q[5:2];
    wdata = wbuf_q;
    case (state_q)
      StPack: we = (cnt_q[1:0] == 2'd3);
      StPad:  we = (cnt_q[1:0] == 2'd3);
      StLen: begin
        we = 1'b1;
        waddr = lenph_q ? 4'd15 : 4'd14;
        wdata = lenph_q ? bitlen_q[31:0] : bitlen_q[63:32];
      end
      default: we = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[(state_q == StRd0) ? 4'd0 : rd_addr];
  end

  logic [WordW-1:0] t1, t2;
  assign t1 = v_q[7] + bsig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundConst[rnd_q[5:0]] + w_cur;
  assign t2 = bsig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  // Control and datapath sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      cnt_q     <= '0;
      bitlen_q  <= '0;
      rnd_q     <= '0;
      last_q    <= 1'b0;
      padding_q <= 1'b0;
      marked_q  <= 1'b0;
      oidx_q    <= '0;
      lenph_q   <= 1'b0;
      wbuf_q    <= '0;
      for (int i = 0; i < 8; i++) begin
        h_q[i] <= InitHash[i];
        v_q[i] <= '0;
      end
      for (int i = 0; i < 16; i++) win_q[i] <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (in_if.valid) begin
            padding_q <= in_if.payload.end_of_message;
            marked_q  <= in_if.payload.end_of_message && !in_if.payload.byte_present;
            if (in_if.payload.byte_present) begin
              wbuf_q   <= {wbuf_q[23:0], in_if.payload.data_byte};
              bitlen_q <= bitlen_q + 64'd8;
              state_q  <= StPack;
            end else if (in_if.payload.end_of_message) begin
              wbuf_q  <= {wbuf_q[23:0], 8'h80};
              state_q <= StPad;
            end
          end
        end
        StPack, StPad: begin
          // the word written this cycle is complete when cnt low bits wrap
          cnt_q <= cnt_q + 6'd1;
          if (cnt_q == 6'd63) begin
            last_q  <= 1'b0;
            state_q <= StRd0;
          end else if (state_q == StPad && cnt_q == 6'd55) begin
            lenph_q <= 1'b0;
            state_q <= StLen;
          end else if (state_q == StPad || padding_q) begin
            wbuf_q   <= {wbuf_q[23:0], (state_q == StPad) ? 8'h00 : 8'h80};
            marked_q <= 1'b1;
            state_q  <= StPad;
          end else begin
            state_q <= StIdle;
          end
        end
        StLen: begin
          lenph_q <= ~lenph_q;
          if (lenph_q) begin
            cnt_q   <= '0;
            last_q  <= 1'b1;
            state_q <= StRd0;
          end
        end
        StRd0: begin
          rnd_q <= '0;
          for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
          state_q <= StRound;
        end
        StRound: begin
          for (int i = 0; i < 15; i++) win_q[i] <= win_q[i+1];
          win_q[15] <= w_cur;
          v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          rnd_q  <= rnd_q + 7'd1;
          if (rnd_q == 7'(NumRounds - 1)) state_q <= StFin;
        end
        StFin: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          if (last_q) begin
            oidx_q  <= '0;
            state_q <= StOut;
          end else if (padding_q) begin
            // block filled before the length fit: the marker, or a zero pad byte if already marked, opens the next one
            wbuf_q   <= {wbuf_q[23:0], marked_q ? 8'h00 : 8'h80};
            marked_q <= 1'b1;
            state_q  <= StPad;
          end else begin
            state_q <= StIdle;
          end
        end
        StOut: begin
          if (out_if.ready) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              for (int i = 0; i < 8; i++) h_q[i] <= InitHash[i];
              bitlen_q  <= '0;
              cnt_q     <= '0;
              padding_q <= 1'b0;
              marked_q  <= 1'b0;
              last_q    <= 1'b0;
              state_q   <= StIdle;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ===== tb/sha256_message_digest_core_test.sv =====
// Self-checking bench for the byte-serial SHA-256 core: random messages in,
// digest words checked against a behavioral hash model.
// Depends on sha256_pkg, sha256_if and sha256_message_digest_core.
`timescale 1ns / 1ps
module sha256_message_digest_core_test;
  import sha256_pkg::*;

  // Digest predictor and store of expected digest words
  class digest_scoreboard;
    logic [31:0] hash_words [8];
    logic [31:0] block_buf [16];
    logic [63:0] msg_bits;
    int unsigned byte_cnt;
    out_item_t pending_words [$];
    int unsigned error_cnt;

    function new();
      error_cnt = 0;
      restart();
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hash_words[i] = InitHash[i];
      msg_bits = '0;
      byte_cnt = 0;
    endfunction

    function logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, t1, t2, a, e, w15, w2;
      for (int i = 0; i < 16; i++) w[i] = block_buf[i];
      for (int i = 0; i < 8; i++) v[i] = hash_words[i];
      for (int r = 0; r < 64; r++) begin
        if (r < 16) begin
          wt = w[r];
        end else begin
          w15 = w[(r + 1) & 15];
          w2 = w[(r + 14) & 15];
          wt = w[r & 15] + (ror(w15, 7) ^ ror(w15, 18) ^ (w15 >> 3)) + w[(r + 9) & 15]
               + (ror(w2, 17) ^ ror(w2, 19) ^ (w2 >> 10));
          w[r & 15] = wt;
        end
        a = v[0];
        e = v[4];
        t1 = v[7] + (ror(e, 6) ^ ror(e, 11) ^ ror(e, 25)) + ((e & v[5]) ^ (~e & v[6]))
             + RoundConst[r] + wt;
        t2 = (ror(a, 2) ^ ror(a, 13) ^ ror(a, 22)) + ((a & v[1]) ^ (a & v[2]) ^ (v[1] & v[2]));
        for (int k = 7; k > 0; k--) v[k] = v[k-1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_words[i] += v[i];
    endfunction

    function void put_byte(logic [7:0] b);
      if (byte_cnt % 4 == 0) block_buf[byte_cnt / 4] = '0;
      block_buf[byte_cnt / 4] = {block_buf[byte_cnt / 4][23:0], b};
      byte_cnt = (byte_cnt + 1) % 64;
      if (byte_cnt == 0) compress();
    endfunction

    // Note an accepted message item
    function void note_item(in_item_t it);
      out_item_t o;
      if (it.byte_present) begin
        put_byte(it.data_byte);
        msg_bits += 64'd8;
      end
      if (!it.end_of_message) return;
      put_byte(8'h80);
      while (byte_cnt != 56) put_byte(8'h00);
      block_buf[14] = msg_bits[63:32];
      block_buf[15] = msg_bits[31:0];
      compress();
      for (int k = 0; k < 8; k++) begin
        o.digest_word = hash_words[k];
        o.word_index = 3'(k);
        o.last_word = (k == 7);
        pending_words.push_back(o);
      end
      restart();
    endfunction

    // Check one accepted digest word against the oldest expectation
    function void check_word(out_item_t got);
      out_item_t exp_w;
      if (pending_words.size() == 0) begin
        $error("unexpected digest word %h", got.digest_word);
        error_cnt++;
        return;
      end
      exp_w = pending_words.pop_front();
      if (got.digest_word !== exp_w.digest_word) begin
        $error("digest_word: expected %h, got %h", exp_w.digest_word, got.digest_word);
        error_cnt++;
      end
      if (got.word_index !== exp_w.word_index) begin
        $error("word_index: expected %0d, got %0d", exp_w.word_index, got.word_index);
        error_cnt++;
      end
      if (got.last_word !== exp_w.last_word) begin
        $error("last_word: expected %0b, got %0b", exp_w.last_word, got.last_word);
        error_cnt++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  sha256_in_if in_ch();
  sha256_out_if out_ch();
  digest_scoreboard sb = new();
  int unsigned cycle_cnt = 0;
  int unsigned burst_left = 0;
  int unsigned stall_phase = 0;

  localparam int unsigned CycleLimit = 400000;

  sha256_message_digest_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_if (in_ch.sink),
    .out_if(out_ch.source)
  );

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver: own stall pattern, with quiet stretches of full readiness
  always @(posedge clk_i) begin
    if (rst_ni && out_ch.valid && out_ch.ready) sb.check_word(out_ch.payload);
    stall_phase <= stall_phase + 1;
    if (stall_phase[9:8] == 2'd0) out_ch.ready <= 1'b1;
    else if (stall_phase[9:8] == 2'd1) out_ch.ready <= ($urandom_range(0, 3) != 0);
    else out_ch.ready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 9) != 0);
  end

  // Send one item; bursts of random length with random gaps between them
  task automatic send_item(logic [7:0] b, logic present, logic last);
    in_item_t it;
    it.data_byte = b;
    it.byte_present = present;
    it.end_of_message = last;
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.payload <= it;
    do @(posedge clk_i); while (!in_ch.ready);
    sb.note_item(it);
  endtask

  task automatic send_message(int unsigned len, bit empty_last, bit noise);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise && $urandom_range(0, 7) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      if (i == len - 1 && !empty_last) send_item(8'($urandom), 1'b1, 1'b1);
      else send_item(8'($urandom), 1'b1, 1'b0);
    end
    if (empty_last || len == 0) send_item(8'($urandom), 1'b0, 1'b1);
  endtask

  initial begin
    int unsigned sent;
    int unsigned len;
    in_ch.valid <= 1'b0;
    in_ch.payload <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed: empty message, byte extremes, idle item, one-byte message
    send_item(8'hff, 1'b0, 1'b1);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h5a, 1'b0, 1'b0);
    send_item(8'hff, 1'b1, 1'b0);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b1);
    // Random: lengths near padding boundaries (55, 56, 63, 64, 65) and short ones
    sent = 7;
    while (sent < 430) begin
      case ($urandom_range(0, 5))
        0: len = 55 + $urandom_range(0, 1);
        1: len = 63 + $urandom_range(0, 2);
        2: len = 0;
        default: len = $urandom_range(1, 20);
      endcase
      send_message(len, $urandom_range(0, 2) == 0, $urandom_range(0, 1));
      sent += len + 1;
    end
    in_ch.valid <= 1'b0;
    while (sb.pending_words.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    if (sb.error_cnt == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

// ===== sha256_message_digest_core.f =====
rtl/sha256_pkg.sv
rtl/sha256_if.sv
rtl/sha256_message_digest_core.sv
tb/sha256_message_digest_core_test.sv
